FILE: hdl/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [0:7][31:0]  t_hash;   // [0] = a / h0 ... [7] = h / h7
    typedef logic [0:15][31:0] t_win;    // [0] = oldest schedule word

    typedef struct packed {
        logic init;     // working vars <= chain
        logic step;     // one compression round
        logic fold;     // chain <= chain + working vars
        logic restart;  // chain <= initial value
    } t_rnd_ctl;

    typedef struct packed {
        logic push;     // shift one message byte in
        logic step;     // shift one schedule word in
    } t_win_ctl;

    localparam t_hash HASH_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_RND  = 6'd63;

    localparam t_word K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sig0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sig1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sig0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sig1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

FILE: hdl/sha256_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_if
// Valid/ready channels: message bytes in, digest words out.
// ----------------------------------------------------------------------------
interface sha256_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       msg_end;

    modport source (output valid, data_byte, byte_valid, msg_end, input ready);
    modport sink   (input valid, data_byte, byte_valid, msg_end, output ready);
endinterface

interface sha256_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic        digest_last;

    modport source (output valid, digest_word, digest_last, input ready);
    modport sink   (input valid, digest_word, digest_last, output ready);
endinterface
`default_nettype wire

FILE: hdl/sha256_sched.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_sched
// Block buffer and message schedule: a 16-word shift line that gathers the
// message bytes and then expands them one schedule word per round.
// ----------------------------------------------------------------------------
module sha256_sched (
    input  wire                        i_clk,
    input  wire sha256_pkg::t_win_ctl  i_ctl,
    input  wire  [7:0]                 i_byte,
    output sha256_pkg::t_word          o_w
);

    sha256_pkg::t_win  r_win;
    sha256_pkg::t_win  n_win;
    sha256_pkg::t_word w_new;
    logic [511:0]      win_flat;

    assign win_flat = r_win;
    assign w_new = sha256_pkg::small_sig1(r_win[14]) + r_win[9]
                 + sha256_pkg::small_sig0(r_win[1]) + r_win[0];
    assign o_w = r_win[0];

    always_comb begin
        n_win = r_win;
        if (i_ctl.push) begin
            n_win = {win_flat[503:0], i_byte};
        end else if (i_ctl.step) begin
            n_win = {win_flat[479:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule
`default_nettype wire

FILE: hdl/sha256_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_round
// Shared compression round with working variables and chaining words.
// ----------------------------------------------------------------------------
module sha256_round (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire sha256_pkg::t_rnd_ctl  i_ctl,
    input  wire  [5:0]                 i_round,
    input  wire sha256_pkg::t_word     i_w,
    output sha256_pkg::t_hash          o_chain
);

    sha256_pkg::t_hash r_work;
    sha256_pkg::t_hash n_work;
    sha256_pkg::t_hash r_chain;
    sha256_pkg::t_hash n_chain;
    sha256_pkg::t_word t1;
    sha256_pkg::t_word t2;
    sha256_pkg::t_word ch;
    sha256_pkg::t_word mj;

    assign ch = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
    assign mj = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2])
              ^ (r_work[1] & r_work[2]);
    assign t1 = r_work[7] + sha256_pkg::big_sig1(r_work[4]) + ch
              + sha256_pkg::K_ROUND[i_round] + i_w;
    assign t2 = sha256_pkg::big_sig0(r_work[0]) + mj;
    assign o_chain = r_chain;

    always_comb begin
        n_work  = r_work;
        n_chain = r_chain;
        if (i_ctl.init) begin
            n_work = r_chain;
        end else if (i_ctl.step) begin
            n_work[0] = t1 + t2;
            n_work[1] = r_work[0];
            n_work[2] = r_work[1];
            n_work[3] = r_work[2];
            n_work[4] = r_work[3] + t1;
            n_work[5] = r_work[4];
            n_work[6] = r_work[5];
            n_work[7] = r_work[6];
        end
        if (i_ctl.restart) begin
            n_chain = sha256_pkg::HASH_INIT;
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                n_chain[i] = r_chain[i] + r_work[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= sha256_pkg::HASH_INIT;
        end else begin
            r_chain <= n_chain;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/sha256_byte_stream_hash_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_byte_stream_hash_top
// SHA-256 of a byte stream: one message byte per input transaction, the
// 256-bit digest as four 64-bit output transactions (h0/h1 first).
//
// i_byte carries data_byte, byte_valid and msg_end; o_digest carries
// digest_word and digest_last (set on the fourth word).
// A byte that does not complete a 64-byte block is shifted into the buffer.
// A byte that completes one holds off new bytes while the working variables
// are loaded, 64 rounds run through the single round unit and a fold
// follows. On msg_end the padding bytes are pushed one per cycle (1 to 64 of
// them plus the 8 length bytes), with a compression per full block; then the
// four words enter the output register one per cycle while it is free.
// Reset restores the initial chaining value and clears the byte count and
// fill level. A stalled receiver holds the output register; the block keeps
// taking new bytes once the last word is loaded, but waits before loading a
// word while the previous one is still untaken.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hash_top (
    input  wire              i_clk,
    input  wire              i_rst_n,
    sha256_byte_if.sink      i_byte,
    sha256_digest_if.source  o_digest
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_COMP = 5'b00100,
        S_FOLD = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state       r_state, n_state;
    t_state       r_after, n_after;
    logic [5:0]   r_fill, n_fill;
    logic [60:0]  r_total, n_total;
    logic [63:0]  r_len, n_len;
    logic         r_mark, n_mark;
    logic         r_len_phase, n_len_phase;
    logic [2:0]   r_len_cnt, n_len_cnt;
    logic [5:0]   r_round, n_round;
    logic [1:0]   r_oidx, n_oidx;
    logic         r_out_valid, n_out_valid;
    logic [63:0]  r_out_word, n_out_word;
    logic         r_out_last, n_out_last;

    sha256_pkg::t_rnd_ctl rnd_ctl;
    sha256_pkg::t_win_ctl win_ctl;
    logic [7:0]           push_byte;
    sha256_pkg::t_word    sched_w;
    sha256_pkg::t_hash    chain;
    logic                 in_fire;
    logic [5:0]           fill_inc;
    logic [60:0]          total_after;
    logic                 last_len;

    assign i_byte.ready         = (r_state == S_IDLE);
    assign in_fire              = i_byte.valid && i_byte.ready;
    assign fill_inc             = r_fill + 6'd1;
    assign total_after          = r_total + {60'd0, i_byte.byte_valid};
    assign last_len             = !r_mark && r_len_phase && (r_len_cnt == 3'd7);
    assign o_digest.valid       = r_out_valid;
    assign o_digest.digest_word = r_out_word;
    assign o_digest.digest_last = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_fill      = r_fill;
        n_total     = r_total;
        n_len       = r_len;
        n_mark      = r_mark;
        n_len_phase = r_len_phase;
        n_len_cnt   = r_len_cnt;
        n_round     = r_round;
        n_oidx      = r_oidx;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        n_out_last  = r_out_last;
        rnd_ctl     = '0;
        win_ctl     = '0;
        push_byte   = i_byte.data_byte;

        if (o_digest.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_byte.byte_valid) begin
                        win_ctl.push = 1'b1;
                        n_total      = total_after;
                        n_fill       = fill_inc;
                    end
                    if (i_byte.msg_end) begin
                        n_mark      = 1'b1;
                        n_len_phase = 1'b0;
                        n_len_cnt   = 3'd0;
                        n_len       = {total_after, 3'b000};
                    end
                    if (i_byte.byte_valid && fill_inc == 6'd0) begin
                        rnd_ctl.init = 1'b1;
                        n_round      = 6'd0;
                        n_state      = S_COMP;
                        n_after      = i_byte.msg_end ? S_PAD : S_IDLE;
                    end else if (i_byte.msg_end) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                win_ctl.push = 1'b1;
                n_fill       = fill_inc;
                if (r_mark) begin
                    push_byte = sha256_pkg::PAD_MARK;
                    n_mark    = 1'b0;
                end else if (r_len_phase) begin
                    push_byte = r_len[63:56];
                    n_len     = {r_len[55:0], 8'd0};
                    n_len_cnt = r_len_cnt + 3'd1;
                end else begin
                    push_byte = 8'd0;
                end
                if (!r_len_phase && fill_inc == sha256_pkg::LEN_START) begin
                    n_len_phase = 1'b1;
                end
                if (last_len) begin
                    n_len_phase = 1'b0;
                end
                if (fill_inc == 6'd0) begin
                    rnd_ctl.init = 1'b1;
                    n_round      = 6'd0;
                    n_state      = S_COMP;
                    n_after      = last_len ? S_OUT : S_PAD;
                end
            end
            S_COMP: begin
                rnd_ctl.step = 1'b1;
                win_ctl.step = 1'b1;
                n_round      = r_round + 6'd1;
                if (r_round == sha256_pkg::LAST_RND) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                rnd_ctl.fold = 1'b1;
                n_oidx       = 2'd0;
                n_state      = r_after;
            end
            S_OUT: begin
                if (!r_out_valid || o_digest.ready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = {chain[{r_oidx, 1'b0}], chain[{r_oidx, 1'b1}]};
                    n_out_last  = (r_oidx == 2'd3);
                    n_oidx      = r_oidx + 2'd1;
                    if (r_oidx == 2'd3) begin
                        rnd_ctl.restart = 1'b1;
                        n_total         = '0;
                        n_fill          = 6'd0;
                        n_state         = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= 6'd0;
            r_total     <= '0;
            r_mark      <= 1'b0;
            r_len_phase <= 1'b0;
            r_len_cnt   <= 3'd0;
            r_round     <= 6'd0;
            r_oidx      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_mark      <= n_mark;
            r_len_phase <= n_len_phase;
            r_len_cnt   <= n_len_cnt;
            r_round     <= n_round;
            r_oidx      <= n_oidx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_after    <= n_after;
        r_len      <= n_len;
        r_out_word <= n_out_word;
        r_out_last <= n_out_last;
    end

    sha256_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (win_ctl),
        .i_byte (push_byte),
        .o_w    (sched_w)
    );

    sha256_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rnd_ctl),
        .i_round (r_round),
        .i_w     (sched_w),
        .o_chain (chain)
    );

`ifndef NO_ASSERTIONS
    a_out_on_block_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_fill == 6'd0))
        else $error("digest read out with a partial block pending");

    a_round_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP && r_round != sha256_pkg::LAST_RND)
        |=> (r_state == S_COMP && r_round == $past(r_round) + 6'd1))
        else $error("compression round sequence broken");

    a_len_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD && r_len_phase) |-> (r_fill >= sha256_pkg::LEN_START))
        else $error("length bytes placed before offset 56");
`endif

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SHA-256 byte stream hasher. Messages of
// directed and random lengths, including padding boundary lengths, are sent
// one byte per transaction with idle and end-only items mixed in. Each
// digest word is checked against an in-bench SHA-256 model under random
// source idles and random back-pressure on the digest channel.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       msg_end;
    } t_byte_item;

    typedef struct {
        logic [63:0] word;
        logic        last;
    } t_digest_beat;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam int BOUNDARY_LEN [6] = '{55, 56, 57, 63, 64, 65};

    logic i_clk;
    logic i_rst_n;

    sha256_byte_if   byte_ch ();
    sha256_digest_if digest_ch ();

    sha256_byte_stream_hash_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_digest (digest_ch)
    );

    t_byte_item   pending_bytes [$];
    t_digest_beat expected_digest [$];

    // hash model state
    logic [31:0] chain_st [8];
    logic [60:0] msg_len_bytes;
    logic [7:0]  blk_buf [64];
    logic [5:0]  blk_fill;

    int  n_total;
    int  items_done;
    int  words_checked;
    int  err_count;
    int  quiet_cycles;
    int  n_msgs;
    int  n_msg_bytes;
    int  n_idle;
    logic byte_taken;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
        return (x >> r) | (x << (32 - r));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, ch, mj;
        int t;
        for (t = 0; t < 16; t++) begin
            w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
        end
        for (t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (t = 0; t < 8; t++) begin
            v[t] = chain_st[t];
        end
        for (t = 0; t < 64; t++) begin
            s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + SHA_K[t] + w[t];
            s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2 = s0 + mj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (t = 0; t < 8; t++) begin
            chain_st[t] = chain_st[t] + v[t];
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        blk_buf[blk_fill] = b;
        blk_fill = blk_fill + 6'd1;
        if (blk_fill == 6'd0) begin
            compress_block();
        end
    endtask

    task automatic restart_hash();
        int i;
        for (i = 0; i < 8; i++) begin
            chain_st[i] = SHA_IV[i];
        end
        msg_len_bytes = '0;
        blk_fill = '0;
    endtask

    task automatic predict_digest(input t_byte_item it);
        logic [63:0] bit_len;
        t_digest_beat beat;
        int k;
        if (it.byte_valid) begin
            msg_len_bytes = msg_len_bytes + 61'd1;
            absorb_byte(it.data_byte);
        end
        if (it.msg_end) begin
            bit_len = {msg_len_bytes, 3'b000};
            absorb_byte(8'h80);
            while (blk_fill != 6'd56) begin
                absorb_byte(8'h00);
            end
            for (k = 0; k < 8; k++) begin
                absorb_byte(bit_len[63 - 8*k -: 8]);
            end
            for (k = 0; k < 4; k++) begin
                beat.word = {chain_st[2*k], chain_st[2*k+1]};
                beat.last = (k == 3);
                expected_digest.push_back(beat);
            end
            restart_hash();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic queue_item(input logic [7:0] d, input logic bv, input logic me);
        t_byte_item it;
        it.data_byte = d;
        it.byte_valid = bv;
        it.msg_end = me;
        pending_bytes.push_back(it);
        if (bv) begin
            n_msg_bytes++;
        end
        if (!bv && !me) begin
            n_idle++;
        end
        if (me) begin
            n_msgs++;
        end
    endtask

    // random content; ends either on the last byte or with an end-only item
    task automatic queue_message(input int len, output int n_items);
        int i;
        logic end_on_byte;
        n_items = 0;
        end_on_byte = (len > 0) && ($urandom_range(1) == 1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) begin
                queue_item(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            queue_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
            n_items++;
        end
        if (!end_on_byte) begin
            queue_item(8'($urandom_range(255)), 1'b0, 1'b1);
            n_items++;
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        int phase;
        int tx_idle_pct;
        int rx_idle_pct;
        phase = (n_total > 0) ? (items_done * 3) / n_total : 0;
        case (phase)
            0: begin
                tx_idle_pct = 34;
                rx_idle_pct = 63;
            end
            1: begin
                tx_idle_pct = 63;
                rx_idle_pct = 34;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else if (!byte_ch.valid || byte_taken) begin
            if (pending_bytes.size() == 0 || $urandom_range(99) < tx_idle_pct) begin
                byte_ch.valid <= 1'b0;
            end else begin
                byte_ch.valid      <= 1'b1;
                byte_ch.data_byte  <= pending_bytes[0].data_byte;
                byte_ch.byte_valid <= pending_bytes[0].byte_valid;
                byte_ch.msg_end    <= pending_bytes[0].msg_end;
            end
        end
        digest_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // input acceptance, digest monitor and quiet-cycle count
    always @(posedge i_clk) begin
        logic acc_in;
        logic acc_out;
        t_digest_beat want;
        acc_in  = (byte_ch.valid === 1'b1) && (byte_ch.ready === 1'b1);
        acc_out = (digest_ch.valid === 1'b1) && (digest_ch.ready === 1'b1);
        byte_taken <= acc_in;
        if (acc_in) begin
            predict_digest(pending_bytes.pop_front());
            items_done++;
        end
        if (acc_out) begin
            if (expected_digest.size() == 0) begin
                report_mismatch("unexpected digest word", digest_ch.digest_word, '0);
            end else begin
                want = expected_digest.pop_front();
                if (digest_ch.digest_word !== want.word) begin
                    report_mismatch("digest_word", digest_ch.digest_word, want.word);
                end
                if (digest_ch.digest_last !== want.last) begin
                    report_mismatch("digest_last", 64'(digest_ch.digest_last),
                                    64'(want.last));
                end
            end
            words_checked++;
        end
        quiet_cycles <= (acc_in || acc_out) ? 0 : quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(negedge i_clk);
        end
        $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int rnd_items;
        int n;
        int len;
        i_rst_n              = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = 8'h00;
        byte_ch.byte_valid   = 1'b0;
        byte_ch.msg_end      = 1'b0;
        digest_ch.ready      = 1'b0;
        byte_taken           = 1'b0;
        items_done           = 0;
        words_checked        = 0;
        err_count            = 0;
        quiet_cycles         = 0;
        n_msgs               = 0;
        n_msg_bytes          = 0;
        n_idle               = 0;
        n_total              = 0;
        restart_hash();

        // empty message
        queue_item(8'h00, 1'b0, 1'b1);
        // "abc", end flagged on the last byte
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);
        // idle items at both data extremes
        queue_item(8'hff, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b0);
        // extremes, idle inside, end-only close
        queue_item(8'h00, 1'b1, 1'b0);
        queue_item(8'hff, 1'b1, 1'b0);
        queue_item(8'h5a, 1'b0, 1'b0);
        queue_item(8'hff, 1'b0, 1'b1);
        // single byte messages
        queue_item(8'hff, 1'b1, 1'b1);
        queue_item(8'h00, 1'b1, 1'b1);
        // back-to-back empty messages
        queue_item(8'ha5, 1'b0, 1'b1);
        queue_item(8'h3c, 1'b0, 1'b1);

        // one message around the padding boundary, then short ones
        rnd_items = 0;
        queue_message(BOUNDARY_LEN[$urandom_range(5)], n);
        rnd_items += n;
        while (rnd_items < 76) begin
            len = $urandom_range(12);
            queue_message(len, n);
            rnd_items += n;
        end
        n_total = pending_bytes.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (items_done < n_total) begin
            @(negedge i_clk);
        end
        while (expected_digest.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d messages, %0d message bytes and %0d idle items",
                 n_msgs, n_msg_bytes, n_idle);
        $display("over three back-pressure phases; %0d digest words checked, %0d errors",
                 words_checked, err_count);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
